// ===== design/mvd_pkg.sv =====
// Shared constants, types and structs for the mesh vertex deduplicator.
// No dependencies; imported by every other design file but mvd_ram.
`default_nettype none

package mvd_pkg;

    // Table sizing
    localparam int TABLE_SLOTS = 4096;
    localparam int MAX_UNIQUE  = 4096;

    localparam int SLOT_W   = $clog2(TABLE_SLOTS);
    localparam int IDX_W    = $clog2(MAX_UNIQUE);
    localparam int CNT_W    = $clog2(MAX_UNIQUE + 1);
    localparam int VINDEX_W = 12;
    localparam bit SLOTS_POW2 = ((TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0);

    // Vertex key: px py pz nx ny nz u v, element 0 is px
    localparam int NCOMP  = 8;
    localparam int COMP_W = 32;
    localparam int KEY_W  = NCOMP * COMP_W;
    localparam int CIDX_W = $clog2(NCOMP);

    localparam logic [COMP_W-1:0] NEG_ZERO = 32'h8000_0000;

    // Hash
    localparam int HASH_W     = 64;
    localparam int HASH_SHIFT = 29;
    localparam logic [HASH_W-1:0] HASH_SEED = 64'h243F_6A88_85A3_08D3;
    localparam logic [HASH_W-1:0] HASH_MUL  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [31:0] MUL_LO = HASH_MUL[31:0];
    localparam logic [31:0] MUL_HI = HASH_MUL[63:32];
    localparam int MOD_CNT_W = $clog2(HASH_W);

    // Epoch marks: zero never matches a live mesh
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};

    localparam int META_W = EPOCH_W + IDX_W;

    typedef logic [NCOMP-1:0][COMP_W-1:0] comp_vec_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [IDX_W-1:0]   idx;
    } mvd_meta_t;

    typedef struct packed {
        comp_vec_t         key;
        logic [SLOT_W-1:0] home;
        logic              new_mesh;
    } mvd_lookup_t;

    typedef struct packed {
        logic [VINDEX_W-1:0] vtx_index;
        logic                is_new;
        logic                table_full;
    } mvd_result_t;

    typedef struct packed {
        logic ready;
        logic done;
    } mvd_tbl_status_t;

endpackage

`default_nettype wire

// ===== design/mvd_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module mvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/mvd_hash.sv =====
// Iterative vertex hash and home-slot reduction.
// Depends on mvd_pkg. One shared 32x32 multiplier, three passes per component.
`default_nettype none

module mvd_hash
    import mvd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire comp_vec_t         comps,
    output logic                   done,
    output logic [SLOT_W-1:0]      home
);

    typedef enum logic [4:0] {
        H_IDLE = 5'b00001,
        H_MUL0 = 5'b00010,
        H_MUL1 = 5'b00100,
        H_MUL2 = 5'b01000,
        H_MOD  = 5'b10000
    } hash_state_t;

    hash_state_t state_reg, state_next;
    logic [CIDX_W-1:0]    idx_reg, idx_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [HASH_W-1:0]    h_reg, h_next;
    logic [HASH_W-1:0]    x_reg, x_next;
    logic [HASH_W-1:0]    acc_reg, acc_next;
    logic [SLOT_W-1:0]    rem_reg, rem_next;

    logic [31:0]       mul_a, mul_b;
    logic [63:0]       prod;
    logic [HASH_W-1:0] x_mix, sum, h_mixed;
    logic [SLOT_W:0]   trial, trial_red;

    assign prod    = mul_a * mul_b;
    assign x_mix   = h_reg ^ {32'b0, comps[idx_reg]};
    assign sum     = acc_reg + {prod[31:0], 32'b0};
    assign h_mixed = sum ^ (sum >> HASH_SHIFT);
    assign trial   = {rem_reg, h_reg[HASH_W-1]};

    always_comb
    begin
        if (trial >= (SLOT_W + 1)'(TABLE_SLOTS))
        begin
            trial_red = trial - (SLOT_W + 1)'(TABLE_SLOTS);
        end
        else
        begin
            trial_red = trial;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        h_next     = h_reg;
        x_next     = x_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        mul_a      = '0;
        mul_b      = '0;
        case (state_reg)
            H_IDLE:
            begin
                if (start)
                begin
                    h_next     = HASH_SEED;
                    idx_next   = '0;
                    state_next = H_MUL0;
                end
            end
            H_MUL0:
            begin
                mul_a      = x_mix[31:0];
                mul_b      = MUL_LO;
                x_next     = x_mix;
                acc_next   = prod;
                state_next = H_MUL1;
            end
            H_MUL1:
            begin
                mul_a      = x_reg[31:0];
                mul_b      = MUL_HI;
                acc_next   = sum;
                state_next = H_MUL2;
            end
            H_MUL2:
            begin
                mul_a  = x_reg[63:32];
                mul_b  = MUL_LO;
                h_next = h_mixed;
                if (idx_reg == CIDX_W'(NCOMP - 1))
                begin
                    if (SLOTS_POW2)
                    begin
                        rem_next   = h_mixed[SLOT_W-1:0];
                        done_next  = 1'b1;
                        state_next = H_IDLE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = H_MOD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = H_MUL0;
                end
            end
            H_MOD:
            begin
                // restoring reduction, one hash bit per cycle, MSB first
                rem_next = trial_red[SLOT_W-1:0];
                h_next   = h_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MOD_CNT_W'(HASH_W - 1))
                begin
                    done_next  = 1'b1;
                    state_next = H_IDLE;
                end
            end
            default:
            begin
                state_next = H_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            idx_reg   <= '0;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        h_reg   <= h_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign home = rem_reg;

endmodule

`default_nettype wire

// ===== design/mvd_table.sv =====
// Hash table engine: linear probing over key and metadata RAMs, epoch-based clear.
// Depends on mvd_pkg and mvd_ram.
`default_nettype none

module mvd_table
    import mvd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire mvd_lookup_t  lookup,
    output mvd_tbl_status_t   status,
    output mvd_result_t       result
);

    typedef enum logic [3:0] {
        T_CLEAR = 4'b0001,
        T_IDLE  = 4'b0010,
        T_READ  = 4'b0100,
        T_CMP   = 4'b1000
    } tbl_state_t;

    tbl_state_t state_reg, state_next;
    logic [EPOCH_W-1:0] epoch_reg, epoch_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]  clr_addr_reg, clr_addr_next;
    logic               resume_reg, resume_next;
    logic               done_reg, done_next;
    logic [SLOT_W-1:0]  slot_reg, slot_next;
    logic [SLOT_W-1:0]  probes_reg, probes_next;
    comp_vec_t          key_reg, key_next;
    mvd_result_t        result_reg, result_next;

    logic              meta_we, rd_en, key_we;
    logic [SLOT_W-1:0] meta_waddr;
    mvd_meta_t         meta_wr, meta_rd;
    logic [META_W-1:0] meta_rdata;
    logic [KEY_W-1:0]  key_rdata;
    logic              slot_used, key_match;

    mvd_ram #(
        .WIDTH (META_W),
        .DEPTH (TABLE_SLOTS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wr),
        .re    (rd_en),
        .raddr (slot_reg),
        .rdata (meta_rdata)
    );

    mvd_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (slot_reg),
        .wdata (key_reg),
        .re    (rd_en),
        .raddr (slot_reg),
        .rdata (key_rdata)
    );

    assign meta_rd   = mvd_meta_t'(meta_rdata);
    assign slot_used = (meta_rd.epoch == epoch_reg);
    assign key_match = (key_rdata == key_reg);

    always_comb
    begin
        state_next    = state_reg;
        epoch_next    = epoch_reg;
        count_next    = count_reg;
        clr_addr_next = clr_addr_reg;
        resume_next   = resume_reg;
        done_next     = 1'b0;
        slot_next     = slot_reg;
        probes_next   = probes_reg;
        key_next      = key_reg;
        result_next   = result_reg;
        meta_we       = 1'b0;
        meta_waddr    = slot_reg;
        meta_wr       = '0;
        key_we        = 1'b0;
        rd_en         = 1'b0;
        case (state_reg)
            T_CLEAR:
            begin
                meta_we       = 1'b1;
                meta_waddr    = clr_addr_reg;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    resume_next = 1'b0;
                    state_next  = resume_reg ? T_READ : T_IDLE;
                end
            end
            T_IDLE:
            begin
                if (start)
                begin
                    key_next    = lookup.key;
                    slot_next   = lookup.home;
                    probes_next = '0;
                    state_next  = T_READ;
                    if (lookup.new_mesh)
                    begin
                        count_next = '0;
                        if (epoch_reg == EPOCH_MAX)
                        begin
                            // marks exhausted: wipe metadata, then probe
                            epoch_next    = EPOCH_FIRST;
                            clr_addr_next = '0;
                            resume_next   = 1'b1;
                            state_next    = T_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + 1'b1;
                        end
                    end
                end
            end
            T_READ:
            begin
                rd_en      = 1'b1;
                state_next = T_CMP;
            end
            T_CMP:
            begin
                if (!slot_used)
                begin
                    if (count_reg < CNT_W'(MAX_UNIQUE))
                    begin
                        meta_we       = 1'b1;
                        meta_wr.epoch = epoch_reg;
                        meta_wr.idx   = IDX_W'(count_reg);
                        key_we        = 1'b1;
                        result_next.vtx_index  = VINDEX_W'(count_reg);
                        result_next.is_new     = 1'b1;
                        result_next.table_full = 1'b0;
                        count_next    = count_reg + 1'b1;
                    end
                    else
                    begin
                        result_next.vtx_index  = '0;
                        result_next.is_new     = 1'b0;
                        result_next.table_full = 1'b1;
                    end
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end
                else if (key_match)
                begin
                    result_next.vtx_index  = VINDEX_W'(meta_rd.idx);
                    result_next.is_new     = 1'b0;
                    result_next.table_full = 1'b0;
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end
                else if (probes_reg == SLOT_W'(TABLE_SLOTS - 1))
                begin
                    // every slot visited, none free
                    result_next.vtx_index  = '0;
                    result_next.is_new     = 1'b0;
                    result_next.table_full = 1'b1;
                    done_next  = 1'b1;
                    state_next = T_IDLE;
                end
                else
                begin
                    if (slot_reg == SLOT_W'(TABLE_SLOTS - 1))
                    begin
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                    end
                    probes_next = probes_reg + 1'b1;
                    state_next  = T_READ;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= T_CLEAR;
            epoch_reg    <= EPOCH_FIRST;
            count_reg    <= '0;
            clr_addr_reg <= '0;
            resume_reg   <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            epoch_reg    <= epoch_next;
            count_reg    <= count_next;
            clr_addr_reg <= clr_addr_next;
            resume_reg   <= resume_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg   <= slot_next;
        probes_reg <= probes_next;
        key_reg    <= key_next;
        result_reg <= result_next;
    end

    assign status.ready = (state_reg == T_IDLE);
    assign status.done  = done_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

// ===== design/mesh_vertex_deduplicator.sv =====
// Top level of the mesh vertex deduplicator: input capture, sequencing, output register.
// Depends on mvd_pkg, mvd_hash, mvd_table (and through it mvd_ram).
`default_nettype none

// Accepts one mesh corner per transaction and returns one result transaction
// with the index of the first identical vertex, or a fresh index flagged
// is_new, or table_full when no vertex can be stored. Components are compared
// as float bit patterns, with -0 folded to +0; a missing normal or texture
// coordinate counts as zeros. first_of_mesh empties the table before that
// corner is looked up. An accepted corner is hashed (eight components, three
// passes each through one shared 32x32 multiplier), its home slot is handed
// to the table, each probe does a registered read of the key and metadata RAMs
// and then a compare and write back, and the table's registered result is
// copied into the output register from the S_DONE state. Only the home slot
// is probed when it is free or matches. If TABLE_SLOTS is not a power of two,
// a bit-serial home-slot reduction follows the hash. One corner is in flight
// at a time; the next corner is taken as soon as the result sits in the output
// register, even while it is stalled. After reset the block runs a clearing
// pass over the metadata RAM with in_stall high; the same pass runs again on the
// first corner of every 255th mesh, when the mesh epoch mark wraps.
module mesh_vertex_deduplicator
    import mvd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // input corner channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 first_of_mesh,
    input  wire logic [COMP_W-1:0]    pos_x,
    input  wire logic [COMP_W-1:0]    pos_y,
    input  wire logic [COMP_W-1:0]    pos_z,
    input  wire logic                 normal_present,
    input  wire logic [COMP_W-1:0]    normal_x,
    input  wire logic [COMP_W-1:0]    normal_y,
    input  wire logic [COMP_W-1:0]    normal_z,
    input  wire logic                 uv_present,
    input  wire logic [COMP_W-1:0]    tex_u,
    input  wire logic [COMP_W-1:0]    tex_v,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [VINDEX_W-1:0]       vtx_index,
    output logic                      is_new,
    output logic                      table_full
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_HASH = 4'b0010,
        S_LOOK = 4'b0100,
        S_DONE = 4'b1000
    } top_state_t;

    // fold -0 to +0; an absent attribute reads as zeros
    function automatic logic [COMP_W-1:0] canon(input logic [COMP_W-1:0] w,
                                                input logic present);
        logic [COMP_W-1:0] r;
        r = (w == NEG_ZERO) ? '0 : w;
        return present ? r : '0;
    endfunction

    top_state_t state_reg, state_next;
    comp_vec_t   comps_reg, comps_next;
    logic        new_mesh_reg, new_mesh_next;
    logic        out_valid_reg, out_valid_next;
    mvd_result_t out_reg, out_next;

    logic            in_accept, out_take, out_free;
    logic            hash_start, hash_done;
    logic [SLOT_W-1:0] hash_home;
    logic            tbl_start;
    mvd_lookup_t     lookup;
    mvd_tbl_status_t tbl_status;
    mvd_result_t     tbl_result;

    assign in_stall  = (state_reg != S_IDLE) || !tbl_status.ready;
    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    assign hash_start = in_accept;
    assign tbl_start  = (state_reg == S_HASH) && hash_done;

    assign lookup.key      = comps_reg;
    assign lookup.home     = hash_home;
    assign lookup.new_mesh = new_mesh_reg;

    mvd_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .comps (comps_next),
        .done  (hash_done),
        .home  (hash_home)
    );

    mvd_table u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (tbl_start),
        .lookup (lookup),
        .status (tbl_status),
        .result (tbl_result)
    );

    always_comb
    begin
        state_next     = state_reg;
        comps_next     = comps_reg;
        new_mesh_next  = new_mesh_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_take;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    comps_next[0] = canon(pos_x, 1'b1);
                    comps_next[1] = canon(pos_y, 1'b1);
                    comps_next[2] = canon(pos_z, 1'b1);
                    comps_next[3] = canon(normal_x, normal_present);
                    comps_next[4] = canon(normal_y, normal_present);
                    comps_next[5] = canon(normal_z, normal_present);
                    comps_next[6] = canon(tex_u, uv_present);
                    comps_next[7] = canon(tex_v, uv_present);
                    new_mesh_next = first_of_mesh;
                    state_next    = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (tbl_status.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // table holds its result until the next lookup starts
                if (out_free)
                begin
                    out_next       = tbl_result;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        comps_reg    <= comps_next;
        new_mesh_reg <= new_mesh_next;
        out_reg      <= out_next;
    end

    assign out_valid  = out_valid_reg;
    assign vtx_index  = out_reg.vtx_index;
    assign is_new     = out_reg.is_new;
    assign table_full = out_reg.table_full;

endmodule

`default_nettype wire

// ===== tb/sv/mesh_vertex_deduplicator_tb.sv =====
// Self-checking testbench for mesh_vertex_deduplicator: directed, pressure, table-load and
// random mesh tests against an in-bench hash-table predictor of the deduplication.
// Depends on mvd_pkg and the mesh_vertex_deduplicator RTL only.
`timescale 1ns / 100ps

module mesh_vertex_deduplicator_tb
    import mvd_pkg::*;
();

    // A correct run spends its cycles on hashing and probing for every corner, random
    // idling on both channels, the long hold-off, the clearing pass after reset and
    // one more at the mesh epoch wrap.
    localparam int CYCLE_LIMIT    = 2_000_000;
    localparam int DRAIN_CYCLES   = 200;     // covers hash latency plus a short probe walk
    localparam int RANDOM_CORNERS = 450;
    localparam int MIN_MESHES     = 270;     // must pass 255 to hit the epoch wrap clear
    localparam int LOAD_CORNERS   = 160;
    localparam int HOLD_CYCLES    = 400;
    localparam int MAX_PRINTED    = 40;

    // Component positions inside a vertex key, px first
    localparam int POS_X = 0;
    localparam int POS_Y = 1;
    localparam int POS_Z = 2;
    localparam int NRM_X = 3;
    localparam int NRM_Y = 4;
    localparam int NRM_Z = 5;
    localparam int TEX_U = 6;
    localparam int TEX_V = 7;

    typedef struct {
        logic      new_mesh;
        logic      has_n;
        logic      has_uv;
        comp_vec_t comp;
    } corner_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                first_of_mesh;
    logic [COMP_W-1:0]   pos_x;
    logic [COMP_W-1:0]   pos_y;
    logic [COMP_W-1:0]   pos_z;
    logic                normal_present;
    logic [COMP_W-1:0]   normal_x;
    logic [COMP_W-1:0]   normal_y;
    logic [COMP_W-1:0]   normal_z;
    logic                uv_present;
    logic [COMP_W-1:0]   tex_u;
    logic [COMP_W-1:0]   tex_v;
    logic                out_valid;
    logic                out_stall;
    logic [VINDEX_W-1:0] vtx_index;
    logic                is_new;
    logic                table_full;

    // Predicted lookup outcomes, oldest first; one entry per accepted corner transaction
    mvd_result_t awaited_lookups[$];

    // Predictor's own copy of the vertex table
    bit          seen_used  [TABLE_SLOTS];
    comp_vec_t   seen_key   [TABLE_SLOTS];
    int unsigned seen_index [TABLE_SLOTS];
    int unsigned seen_count;

    // Idling controls shared by the sender, the result drain and the tests
    bit          calm_in;
    bit          calm_out;
    int unsigned hold_off_cycles;

    int unsigned cycle_count;
    int unsigned mismatches;
    int unsigned corners_sent;
    int unsigned meshes_begun;
    int unsigned results_checked;
    int unsigned fresh_vertices;
    int unsigned full_results;

    mesh_vertex_deduplicator u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_of_mesh  (first_of_mesh),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .normal_present (normal_present),
        .normal_x       (normal_x),
        .normal_y       (normal_y),
        .normal_z       (normal_z),
        .uv_present     (uv_present),
        .tex_u          (tex_u),
        .tex_v          (tex_v),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .vtx_index      (vtx_index),
        .is_new         (is_new),
        .table_full     (table_full)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d lookups still outstanding",
                     cycle_count, awaited_lookups.size());
            $display("mesh_vertex_deduplicator regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // -0 and +0 are one value for hashing and comparing
    function automatic logic [COMP_W-1:0] fold_zero(logic [COMP_W-1:0] w);
        return (w == NEG_ZERO) ? '0 : w;
    endfunction

    // Open-addressed table with linear probing, keyed on the folded components.
    // Absent normal / texture coordinate contributes zeros whatever the port bits hold.
    function automatic mvd_result_t lookup_vertex(corner_t c);
        comp_vec_t         key;
        logic [HASH_W-1:0] h;
        int unsigned       slot;
        mvd_result_t       res;
        if (c.new_mesh)
        begin
            foreach (seen_used[s])
                seen_used[s] = 1'b0;
            seen_count = 0;
        end
        h = HASH_SEED;
        for (int i = 0; i < NCOMP; i++)
        begin
            key[i] = fold_zero(c.comp[i]);
            if (!c.has_n && i >= NRM_X && i <= NRM_Z)
                key[i] = '0;
            if (!c.has_uv && i >= TEX_U)
                key[i] = '0;
            h = (h ^ HASH_W'(key[i])) * HASH_MUL;
            h = h ^ (h >> HASH_SHIFT);
        end
        slot = int'(h % TABLE_SLOTS);
        // default outcome: no match and nowhere to put the vertex
        res.vtx_index  = '0;
        res.is_new     = 1'b0;
        res.table_full = 1'b1;
        for (int probe = 0; probe < TABLE_SLOTS; probe++)
        begin
            if (!seen_used[slot])
            begin
                if (seen_count < MAX_UNIQUE)
                begin
                    seen_used[slot]  = 1'b1;
                    seen_key[slot]   = key;
                    seen_index[slot] = seen_count;
                    res.vtx_index    = VINDEX_W'(seen_count);
                    res.is_new       = 1'b1;
                    res.table_full   = 1'b0;
                    seen_count++;
                end
                return res;
            end
            if (seen_key[slot] == key)
            begin
                res.vtx_index  = VINDEX_W'(seen_index[slot]);
                res.table_full = 1'b0;
                return res;
            end
            slot = (slot + 1) % TABLE_SLOTS;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // No idle when calm; otherwise mostly back-to-back, sometimes a short gap, rarely a long gap
    function automatic int unsigned pick_idle(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // Biased toward zeros of both signs, all-ones, NaN patterns and 1.0
    function automatic logic [COMP_W-1:0] pick_component();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return NEG_ZERO;
            2: return 32'hFFFF_FFFF;
            3: return 32'h7FC0_0000;
            4: return 32'h3F80_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic corner_t make_corner(logic new_mesh, logic has_n, logic has_uv,
                                            logic [COMP_W-1:0] fill);
        corner_t c;
        c.new_mesh = new_mesh;
        c.has_n    = has_n;
        c.has_uv   = has_uv;
        for (int i = 0; i < NCOMP; i++)
            c.comp[i] = fill;
        return c;
    endfunction

    function automatic corner_t random_corner(logic new_mesh);
        corner_t c;
        c.new_mesh = new_mesh;
        c.has_n    = 1'($urandom_range(0, 1));
        c.has_uv   = 1'($urandom_range(0, 1));
        for (int i = 0; i < NCOMP; i++)
            c.comp[i] = pick_component();
        return c;
    endfunction

    // Variants of a pool vertex: exact repeat, zero-sign flips and junk in absent
    // attributes (all still the same vertex), a one-bit change, or a fresh vertex
    function automatic corner_t vary_corner(corner_t c);
        corner_t v;
        int      ci;
        int      bi;
        v = c;
        case ($urandom_range(0, 5))
            0:
            begin
                v = random_corner(1'b0);
            end
            1:
            begin
                for (int i = 0; i < NCOMP; i++)
                    if (v.comp[i][COMP_W-2:0] == '0)
                        v.comp[i][COMP_W-1] = ~v.comp[i][COMP_W-1];
            end
            2:
            begin
                for (int i = NRM_X; i <= NRM_Z; i++)
                    if (!v.has_n)
                        v.comp[i] = $urandom();
                for (int i = TEX_U; i <= TEX_V; i++)
                    if (!v.has_uv)
                        v.comp[i] = $urandom();
            end
            3:
            begin
                ci = $urandom_range(0, NCOMP - 1);
                bi = $urandom_range(0, COMP_W - 1);
                v.comp[ci][bi] = ~v.comp[ci][bi];
            end
            default: ;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Channel handling
    // ------------------------------------------------------------------

    // Offers one corner and holds it until the transaction is taken. valid stays high
    // on return so a following call can stream without a bubble.
    task automatic send_corner(corner_t c);
        int unsigned idle;
        idle = pick_idle(calm_in);
        if (idle != 0)
        begin
            in_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        in_valid       <= 1'b1;
        first_of_mesh  <= c.new_mesh;
        pos_x          <= c.comp[POS_X];
        pos_y          <= c.comp[POS_Y];
        pos_z          <= c.comp[POS_Z];
        normal_present <= c.has_n;
        normal_x       <= c.comp[NRM_X];
        normal_y       <= c.comp[NRM_Y];
        normal_z       <= c.comp[NRM_Z];
        uv_present     <= c.has_uv;
        tex_u          <= c.comp[TEX_U];
        tex_v          <= c.comp[TEX_V];
        // in_stall read here is the value the block presented at this edge
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        awaited_lookups.insert(awaited_lookups.size(), lookup_vertex(c));
        corners_sent++;
        if (c.new_mesh)
            meshes_begun++;
    endtask

    // Sender pause: drop valid and wait for every outstanding result
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_lookups.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Result drain: random stall bursts unless calm_out, or one long hold-off when a test asks for it.
    // The hold is counted here so the sender keeps offering corners meanwhile.
    initial
    begin : result_backpressure
        int unsigned span;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles != 0)
            begin
                span = hold_off_cycles;
                hold_off_cycles = 0;
                out_stall <= 1'b1;
                repeat (span) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (!calm_out && $urandom_range(0, 99) < 20)
            begin
                span = 1 + pick_idle(1'b0);
                out_stall <= 1'b1;
                repeat (span) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Every result transaction is compared with the oldest outstanding prediction
    always @(posedge clk)
    begin : result_check
        mvd_result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (awaited_lookups.size() == 0)
            begin
                report_mismatch("result transaction with no corner outstanding");
            end
            else
            begin
                want = awaited_lookups.pop_front();
                if (vtx_index !== want.vtx_index)
                    report_mismatch($sformatf("result %0d vtx_index %0d, predicted %0d",
                                              results_checked, vtx_index,
                                              want.vtx_index));
                if (is_new !== want.is_new)
                    report_mismatch($sformatf("result %0d is_new %b, predicted %b",
                                              results_checked, is_new, want.is_new));
                if (table_full !== want.table_full)
                    report_mismatch($sformatf("result %0d table_full %b, predicted %b",
                                              results_checked, table_full,
                                              want.table_full));
                if (want.is_new)
                    fresh_vertices++;
                if (want.table_full)
                    full_results++;
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // First corner after reset needs no mesh start; -0, absent normal and absent
    // texture coordinate all collapse onto the all-zero vertex
    task automatic test_signed_zero_and_absent();
        corner_t c;
        c = make_corner(1'b0, 1'b0, 1'b0, '0);
        send_corner(c);
        c.comp[POS_X] = NEG_ZERO;
        send_corner(c);
        c = make_corner(1'b0, 1'b1, 1'b0, NEG_ZERO);
        c.comp[TEX_U] = 32'hFFFF_FFFF;
        c.comp[TEX_V] = 32'hFFFF_FFFF;
        send_corner(c);
        c = make_corner(1'b0, 1'b0, 1'b1, NEG_ZERO);
        c.comp[NRM_X] = 32'hFFFF_FFFF;
        c.comp[NRM_Y] = 32'hFFFF_FFFF;
        c.comp[NRM_Z] = 32'hFFFF_FFFF;
        send_corner(c);
        // neighbors of -0 are ordinary values
        c = make_corner(1'b0, 1'b0, 1'b0, '0);
        c.comp[POS_X] = 32'h8000_0001;
        send_corner(c);
        c.comp[POS_X] = 32'h0000_0001;
        send_corner(c);
        wait_drained();
    endtask

    // NaN patterns match only themselves; component order matters
    task automatic test_nan_and_extremes();
        corner_t c;
        corner_t swapped;
        c = make_corner(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send_corner(c);
        c.new_mesh = 1'b0;
        send_corner(c);
        send_corner(make_corner(1'b0, 1'b1, 1'b1, 32'h7FFF_FFFF));
        send_corner(make_corner(1'b0, 1'b1, 1'b1, 32'h7FC0_0000));
        send_corner(make_corner(1'b0, 1'b1, 1'b1, 32'hAAAA_AAAA));
        send_corner(make_corner(1'b0, 1'b1, 1'b1, 32'h5555_5555));
        c = make_corner(1'b0, 1'b1, 1'b1, '0);
        c.comp[POS_X] = 32'h3F80_0000;
        send_corner(c);
        swapped = make_corner(1'b0, 1'b1, 1'b1, '0);
        swapped.comp[POS_Y] = 32'h3F80_0000;
        send_corner(swapped);
        send_corner(c);
        wait_drained();
    endtask

    // A mesh start empties the table even for back-to-back starts
    task automatic test_mesh_restart();
        corner_t c;
        c = make_corner(1'b1, 1'b0, 1'b0, '0);
        send_corner(c);
        send_corner(c);
        c.new_mesh = 1'b0;
        send_corner(c);
        wait_drained();
    endtask

    // Long receiver hold-off while corners keep coming: the block must back up and
    // stall its input without losing or reordering transactions
    task automatic test_receiver_hold();
        corner_t pool[3];
        corner_t c;
        calm_in  = 1'b1;
        calm_out = 1'b1;
        foreach (pool[i])
            pool[i] = random_corner(1'b0);
        hold_off_cycles = HOLD_CYCLES;
        for (int k = 0; k < 12; k++)
        begin
            c = vary_corner(pool[$urandom_range(0, 2)]);
            c.new_mesh = (k == 0);
            send_corner(c);
        end
        calm_in  = 1'b0;
        calm_out = 1'b0;
        wait_drained();
    endtask

    // One mesh of many distinct positions loads the table so that hash collisions
    // build probe chains; stored vertices must still be found afterwards
    task automatic test_table_load();
        corner_t c;
        corner_t keep[3];
        for (int i = 0; i < LOAD_CORNERS; i++)
        begin
            c = random_corner(i == 0);
            c.comp[POS_X] = COMP_W'(i);
            send_corner(c);
            if (i == 0)
                keep[0] = c;
            if (i == LOAD_CORNERS / 2)
                keep[1] = c;
            if (i == LOAD_CORNERS - 1)
                keep[2] = c;
        end
        foreach (keep[k])
        begin
            keep[k].new_mesh = 1'b0;
            send_corner(keep[k]);
        end
        wait_drained();
    endtask

    // Short meshes built from small vertex pools so repeats are common.
    // Some meshes skip the start flag and grow the previous table; occasional full
    // drains pause the sender. Runs past 255 meshes to cross the epoch wrap.
    task automatic test_random_meshes();
        corner_t     pool[$];
        corner_t     c;
        int unsigned mesh_len;
        int unsigned pool_size;
        int unsigned start_count;
        start_count = corners_sent;
        while (corners_sent - start_count < RANDOM_CORNERS || meshes_begun < MIN_MESHES)
        begin
            calm_in  = ($urandom_range(0, 3) == 0);
            calm_out = ($urandom_range(0, 3) == 0);
            mesh_len = ($urandom_range(0, 99) < 85) ? 1 : $urandom_range(2, 8);
            pool_size = $urandom_range(1, 4);
            pool.delete();
            for (int k = 0; k < pool_size; k++)
                pool.insert(pool.size(), random_corner(1'b0));
            for (int k = 0; k < mesh_len; k++)
            begin
                c = vary_corner(pool[$urandom_range(0, pool_size - 1)]);
                c.new_mesh = (k == 0) && ($urandom_range(0, 9) != 0);
                send_corner(c);
            end
            if ($urandom_range(0, 19) == 0)
                wait_drained();
        end
        calm_in  = 1'b0;
        calm_out = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin : sequencer
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        first_of_mesh  <= 1'b0;
        pos_x          <= '0;
        pos_y          <= '0;
        pos_z          <= '0;
        normal_present <= 1'b0;
        normal_x       <= '0;
        normal_y       <= '0;
        normal_z       <= '0;
        uv_present     <= 1'b0;
        tex_u          <= '0;
        tex_v          <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // the clearing pass after reset shows up as in_stall; send_corner waits it out
        test_signed_zero_and_absent();
        test_nan_and_extremes();
        test_mesh_restart();
        test_receiver_hold();
        test_table_load();
        test_random_meshes();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d corners over %0d meshes in %0d cycles, %0d results checked",
                 corners_sent, meshes_begun, cycle_count, results_checked);
        $display("%0d new vertices, %0d table-full results, %0d mismatches",
                 fresh_vertices, full_results, mismatches);
        if (mismatches == 0)
            $display("mesh_vertex_deduplicator regression: pass");
        else
            $display("mesh_vertex_deduplicator regression: fail");
        $finish;
    end

endmodule
